>>> rtl/life_pkg.sv
// shared types and constants for the game of life block
// no dependencies; used by life_row_unit and life_cellular_automaton_top
`default_nettype none

package life_pkg;

  // request kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS = 2'd1;

  localparam int          CFG_W          = 7;
  localparam logic [6:0]  CFG_RESET_DIM  = 7'd64;

  // b3/s23 rule counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_STEP
  } life_state_t;

endpackage

`default_nettype wire

>>> rtl/life_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module life_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/life_row_unit.sv
// next-generation unit for one grid row: per-column neighbor count and b3/s23 rule
// depends on life_pkg
`default_nettype none

module life_row_unit #(
  parameter int COLS = 64
) (
  input  wire logic [COLS-1:0] above,
  input  wire logic [COLS-1:0] mid,
  input  wire logic [COLS-1:0] below,
  output logic      [COLS-1:0] next_row
);

  logic [COLS+1:0] above_x;
  logic [COLS+1:0] mid_x;
  logic [COLS+1:0] below_x;

  // pad with a dead cell on each side so edges need no special case
  assign above_x = {1'b0, above, 1'b0};
  assign mid_x   = {1'b0, mid, 1'b0};
  assign below_x = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] n;
    n = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 4'(above_x[c]) + 4'(above_x[c+1]) + 4'(above_x[c+2]) +
          4'(mid_x[c])                      + 4'(mid_x[c+2])   +
          4'(below_x[c]) + 4'(below_x[c+1]) + 4'(below_x[c+2]);
      next_row[c] = (n == life_pkg::BIRTH_COUNT) ||
                    (mid[c] && (n == life_pkg::SURVIVE_COUNT));
    end
  end

endmodule

`default_nettype wire

>>> rtl/life_cellular_automaton_top.sv
// Game of life (b3/s23) on a bounded grid of MAX_ROWS x MAX_COLS cells, one grid row per
// ram word. After reset the block is busy while it clears every row of the grid.
// A write holds busy for a read-modify-write of one row, a read holds busy with its result
// strobed on out_valid for one cycle, the same cycle in which busy drops, and a step holds
// busy while the row ram's single read port delivers one row a cycle to the row unit,
// through the ram read register and the above and mid row registers.
// The receiver cannot stall; results are not held.
// Cells outside grid_rows x grid_cols count as dead and are cleared by a step.
// depends on life_pkg, life_ram, life_row_unit
`default_nettype none

module life_cellular_automaton_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_kind,
  input  wire logic [5:0] in_row,
  input  wire logic [5:0] in_col,
  input  wire logic       in_value,
  // result channel
  output logic            out_valid,
  output logic            out_cell_value,
  // configuration channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int CAW  = $clog2(MAX_COLS);
  localparam int CW   = $clog2(MAX_ROWS + 2);
  localparam int CMPW = (CW > life_pkg::CFG_W) ? CW : life_pkg::CFG_W;

  life_pkg::life_state_t state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;

  logic [life_pkg::CFG_W-1:0] rows_r;
  logic [life_pkg::CFG_W-1:0] cols_r;

  logic [AW-1:0]       row_r;
  logic [CAW-1:0]      col_r;
  logic                value_r;
  logic                inside_r;
  logic                out_valid_r;
  logic                out_cell_value_r;

  logic [MAX_COLS-1:0] above_r;
  logic [MAX_COLS-1:0] mid_r;
  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] rule_row;
  logic [MAX_COLS-1:0] rdata;
  logic [MAX_COLS-1:0] modified_row;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MAX_COLS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;

  logic                accept;
  logic                below_live;
  logic                mid_in_use;
  logic [CW-1:0]       cnt_m2;

  assign busy           = (state_r != life_pkg::ST_IDLE);
  assign accept         = start && !busy;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_value_r;

  // columns in use
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(cols_r));
    end
  end

  // during a step, cnt_r = k: rdata holds row k-1, the unit produces row k-2
  assign cnt_m2     = cnt_r - CW'(2);
  assign below_live = (cnt_r != '0) && (cnt_r <= CW'(MAX_ROWS)) &&
                      (CMPW'(cnt_r) <= CMPW'(rows_r));
  assign below      = below_live ? (rdata & col_mask) : '0;
  assign mid_in_use = CMPW'(cnt_m2) < CMPW'(rows_r);

  always_comb begin
    modified_row = rdata;
    modified_row[col_r] = value_r;
  end

  life_row_unit #(
    .COLS (MAX_COLS)
  ) u_row_unit (
    .above    (above_r),
    .mid      (mid_r),
    .below    (below),
    .next_row (rule_row)
  );

  life_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      life_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(MAX_ROWS - 1)) begin
          state_nxt = life_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      life_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          case (in_kind)
            life_pkg::KIND_WRITE: state_nxt = life_pkg::ST_WRITE;
            life_pkg::KIND_READ:  state_nxt = life_pkg::ST_READ;
            life_pkg::KIND_STEP:  state_nxt = life_pkg::ST_STEP;
            default:              state_nxt = life_pkg::ST_IDLE;
          endcase
        end
      end
      life_pkg::ST_READ:  state_nxt = life_pkg::ST_IDLE;
      life_pkg::ST_WRITE: state_nxt = life_pkg::ST_IDLE;
      life_pkg::ST_STEP: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(MAX_ROWS + 1)) begin
          state_nxt = life_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = life_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // ram controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      life_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
      end
      life_pkg::ST_IDLE: begin
        ram_raddr = AW'(in_row);
      end
      life_pkg::ST_WRITE: begin
        ram_we    = inside_r;
        ram_waddr = row_r;
        ram_wdata = modified_row;
      end
      life_pkg::ST_STEP: begin
        ram_raddr = cnt_r[AW-1:0];
        ram_we    = (cnt_r >= CW'(2));
        ram_waddr = cnt_m2[AW-1:0];
        ram_wdata = rule_row & col_mask & {MAX_COLS{mid_in_use}};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= life_pkg::ST_CLEAR;
      cnt_r       <= '0;
      rows_r      <= life_pkg::CFG_RESET_DIM;
      cols_r      <= life_pkg::CFG_RESET_DIM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == life_pkg::ST_READ);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          life_pkg::CFG_GRID_ROWS: rows_r <= cfg_data;
          life_pkg::CFG_GRID_COLS: cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // request payload and step window
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r    <= AW'(in_row);
      col_r    <= CAW'(in_col);
      value_r  <= in_value;
      inside_r <= (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
    end
    if (state_r == life_pkg::ST_IDLE) begin
      above_r <= '0;
      mid_r   <= '0;
    end else if (state_r == life_pkg::ST_STEP) begin
      above_r <= mid_r;
      mid_r   <= below;
    end
    if (state_r == life_pkg::ST_READ) begin
      out_cell_value_r <= inside_r && rdata[col_r];
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_life_cellular_automaton_top.sv
// self-checking testbench for life_cellular_automaton_top: cell writes, reads and generation steps
// predicts the grid in plain sv and checks every read result; needs life_pkg and the block's rtl

module tb_life_cellular_automaton_top;

  localparam int CLK_PERIOD     = 8;
  localparam int GRID_ROWS      = 64;
  localparam int GRID_COLS      = 64;
  localparam int TIMEOUT_CYCLES = 600000;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic       value;
  } life_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_kind = life_pkg::KIND_WRITE;
  logic [5:0] in_row = '0;
  logic [5:0] in_col = '0;
  logic       in_value = 1'b0;
  logic       out_valid;
  logic       out_cell_value;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = life_pkg::CFG_GRID_ROWS;
  logic [6:0] cfg_data = '0;

  // predicted block state
  logic [GRID_COLS-1:0] live_cells [GRID_ROWS];
  logic [6:0]           area_rows = life_pkg::CFG_RESET_DIM;
  logic [6:0]           area_cols = life_pkg::CFG_RESET_DIM;

  life_req_t pending_reqs [$];
  logic      expected_cells [$];
  int        issued_count = 0;
  int        accepted_count = 0;
  int        mismatch_count = 0;
  int        gap_pct = 28;

  life_cellular_automaton_top #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_cell_value(out_cell_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    for (int r = 0; r < GRID_ROWS; r++) live_cells[r] = '0;
  end

  // b3/s23 over the area in use; everything outside it dies
  task automatic advance_generation();
    logic [GRID_COLS-1:0] nxt_grid [GRID_ROWS];
    int nr, nc, cnt, rr, cc;
    nr = (area_rows > GRID_ROWS) ? GRID_ROWS : int'(area_rows);
    nc = (area_cols > GRID_COLS) ? GRID_COLS : int'(area_cols);
    for (int r = 0; r < GRID_ROWS; r++) begin
      nxt_grid[r] = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
        if (r < nr && c < nc) begin
          cnt = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                cnt += live_cells[rr][cc];
            end
          end
          if (live_cells[r][c])
            nxt_grid[r][c] = (cnt == life_pkg::SURVIVE_COUNT || cnt == life_pkg::BIRTH_COUNT);
          else
            nxt_grid[r][c] = (cnt == life_pkg::BIRTH_COUNT);
        end
      end
    end
    live_cells = nxt_grid;
  endtask

  task automatic apply_request(input life_req_t req);
    case (req.kind)
      life_pkg::KIND_WRITE: live_cells[req.row][req.col] = req.value;
      life_pkg::KIND_READ:  expected_cells.push_back(live_cells[req.row][req.col]);
      life_pkg::KIND_STEP:  advance_generation();
      default: ;
    endcase
  endtask

  function automatic void push_req(input logic [1:0] kind, input int row, input int col,
                                   input logic value);
    life_req_t req;
    req.kind  = kind;
    req.row   = 6'(row);
    req.col   = 6'(col);
    req.value = value;
    pending_reqs.push_back(req);
    issued_count++;
  endfunction

  // mostly near the origin so small patterns interact, sometimes anywhere in the grid
  function automatic int pick_index(input int span, input int sel);
    int hot;
    hot = (span < 10) ? span : 10;
    if (sel < 15 || span == 0) return int'($urandom_range(GRID_ROWS - 1));
    if (sel < 65) return int'($urandom_range(hot - 1));
    return int'($urandom_range(span - 1));
  endfunction

  task automatic queue_random_reqs(input int n);
    int use_r, use_c, roll, sel, done;
    use_r = (area_rows > GRID_ROWS) ? GRID_ROWS : int'(area_rows);
    use_c = (area_cols > GRID_COLS) ? GRID_COLS : int'(area_cols);
    done = 0;
    while (done < n) begin
      // open each phase with a burst of writes to seed live patterns
      roll = (done < n / 5) ? 0 : int'($urandom_range(99));
      sel  = (done < n / 5) ? 40 : int'($urandom_range(99));
      if (roll < 40) begin
        push_req(life_pkg::KIND_WRITE, pick_index(use_r, sel), pick_index(use_c, sel),
                 1'($urandom_range(1)));
        done++;
      end else if (roll < 78) begin
        push_req(life_pkg::KIND_READ, pick_index(use_r, sel), pick_index(use_c, sel),
                 1'($urandom_range(1)));
        done++;
      end else if (roll < 93) begin
        push_req(life_pkg::KIND_STEP, $urandom_range(63), $urandom_range(63),
                 1'($urandom_range(1)));
        done++;
      end else begin
        push_req(KIND_UNUSED, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_quiet();
    while (accepted_count != issued_count) @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    // a step or write may still be running with nothing left to report
    repeat (GRID_ROWS + 8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      life_pkg::CFG_GRID_ROWS: area_rows = data;
      life_pkg::CFG_GRID_COLS: area_cols = data;
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    life_req_t cur;
    life_req_t nxt;
    logic      nxt_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        cur = '{kind: in_kind, row: in_row, col: in_col, value: in_value};
        apply_request(cur);
        accepted_count++;
        nxt_start = 1'b0;
      end
      if (!nxt_start && pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = pending_reqs.pop_front();
        in_kind   <= nxt.kind;
        in_row    <= nxt.row;
        in_col    <= nxt.col;
        in_value  <= nxt.value;
        nxt_start = 1'b1;
      end
      start <= nxt_start;
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid) begin
      if (expected_cells.size() == 0) begin
        $error("cell_value: expected no result, got %0d", out_cell_value);
        mismatch_count++;
      end else begin
        want = expected_cells.pop_front();
        if (out_cell_value !== want) begin
          $error("cell_value: expected %0d, got %0d", want, out_cell_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase_rows [9];
    int phase_cols [9];
    int phase_reqs [9];
    phase_rows = '{8, 1, 0, 127, 64, 3, 100, 12, 64};
    phase_cols = '{8, 1, 40, 127, 1, 64, 20, 5, 64};
    phase_reqs = '{300, 80, 80, 200, 80, 150, 150, 260, 400};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // corners, unused kind, a blinker and a block pressed against the far edge
    push_req(life_pkg::KIND_READ, 0, 0, 1'b0);
    push_req(life_pkg::KIND_WRITE, 0, 0, 1'b1);
    push_req(life_pkg::KIND_READ, 0, 0, 1'b0);
    push_req(life_pkg::KIND_WRITE, 63, 63, 1'b1);
    push_req(life_pkg::KIND_READ, 63, 63, 1'b1);
    push_req(life_pkg::KIND_WRITE, 63, 63, 1'b0);
    push_req(KIND_UNUSED, 63, 63, 1'b1);
    push_req(life_pkg::KIND_READ, 63, 63, 1'b0);
    push_req(life_pkg::KIND_WRITE, 10, 9, 1'b1);
    push_req(life_pkg::KIND_WRITE, 10, 10, 1'b1);
    push_req(life_pkg::KIND_WRITE, 10, 11, 1'b1);
    push_req(life_pkg::KIND_STEP, 0, 0, 1'b0);
    push_req(life_pkg::KIND_READ, 9, 10, 1'b0);
    push_req(life_pkg::KIND_READ, 10, 9, 1'b0);
    push_req(life_pkg::KIND_READ, 0, 0, 1'b0);
    push_req(life_pkg::KIND_WRITE, 62, 62, 1'b1);
    push_req(life_pkg::KIND_WRITE, 62, 63, 1'b1);
    push_req(life_pkg::KIND_WRITE, 63, 62, 1'b1);
    push_req(life_pkg::KIND_WRITE, 63, 63, 1'b1);
    push_req(life_pkg::KIND_STEP, 63, 63, 1'b1);
    push_req(life_pkg::KIND_READ, 63, 63, 1'b0);
    push_req(life_pkg::KIND_READ, 0, 0, 1'b0);
    push_req(life_pkg::KIND_READ, 10, 11, 1'b0);
    push_req(life_pkg::KIND_READ, 11, 10, 1'b0);
    wait_quiet();

    for (int p = 0; p < 9; p++) begin
      write_reg(life_pkg::CFG_GRID_ROWS, 7'(phase_rows[p]));
      write_reg(life_pkg::CFG_GRID_COLS, 7'(phase_cols[p]));
      if (p == 3) write_reg(CFG_SPARE_LO, 7'($urandom_range(127)));
      if (p == 6) write_reg(CFG_SPARE_HI, 7'($urandom_range(127)));
      // one long stretch with back-to-back requests
      gap_pct = (p == 0) ? 0 : 28;
      queue_random_reqs(phase_reqs[p]);
      wait_quiet();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
